FILE: rtl/core/tlm_pkg.sv
// Shared types, codes and helpers for the text line metrics unit.
package tlm_pkg;

   // Request kinds
   localparam logic [1:0] KIND_GLYPH = 2'd0;
   localparam logic [1:0] KIND_CHAR  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   // Configuration register indexes and reset values
   localparam logic CSR_FONT_HEIGHT = 1'b0;
   localparam logic CSR_LINE_STEP   = 1'b1;
   localparam int   CSR_DATA_W      = 12;
   localparam logic [10:0] FONT_HEIGHT_RESET = 11'd16;
   localparam logic [11:0] LINE_STEP_RESET   = 12'd20;

   // Field widths (metrics are carried at their widest form)
   localparam int SIZE_W  = 11;
   localparam int BEAR_W  = 12;
   localparam int LEN_W   = 28;
   localparam int POS_W   = 16;
   localparam int LINES_W = 16;
   localparam int DESC_W  = 13;
   localparam int SLACK_W = 14;
   localparam int WIDE_W  = 31;

   localparam logic signed [WIDE_W-1:0] SAT_MAX = 31'sd134217727;
   localparam logic signed [WIDE_W-1:0] SAT_MIN = -31'sd134217728;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0]               kind;
      logic [7:0]               code;
      logic [SIZE_W-1:0]        advance_x;
      logic signed [BEAR_W-1:0] bearing_x;
      logic signed [BEAR_W-1:0] bearing_y;
      logic [SIZE_W-1:0]        size_x;
      logic [SIZE_W-1:0]        size_y;
   } req_data_type;

   typedef struct packed {
      logic                    line_valid;
      logic [POS_W-1:0]        line_start;
      logic [POS_W-1:0]        line_end;
      logic signed [LEN_W-1:0] line_length;
      logic                    is_final;
      logic signed [LEN_W-1:0] text_width;
      logic signed [LEN_W-1:0] text_height;
      logic [SIZE_W-1:0]       first_line_ascent;
   } rsp_data_type;

   // Classified text operation handed from front to back
   typedef enum logic [1:0] {
      OP_GLYPH   = 2'd0,
      OP_BLANK   = 2'd1,
      OP_NEWLINE = 2'd2,
      OP_END     = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [SIZE_W-1:0]        adv;
      logic signed [BEAR_W-1:0] bx;
      logic signed [BEAR_W-1:0] by;
      logic [SIZE_W-1:0]        sx;
      logic [SIZE_W-1:0]        sy;
   } op_item_type;

   // Clamp a wide signed sum to the 28-bit signed range
   function automatic logic signed [LEN_W-1:0] sat_len(input logic signed [WIDE_W-1:0] v);
      logic signed [LEN_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[LEN_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[LEN_W-1:0];
      end else begin
         r = v[LEN_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/tlm_channels.sv
// Request and response channel interfaces of the text line metrics unit.
interface tlm_req_if import tlm_pkg::*; ();
   logic         valid;
   logic         ready;
   req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tlm_rsp_if import tlm_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/tlm_front.sv
// Front end: accepts words, loads the glyph table and classifies text bytes.
module tlm_front import tlm_pkg::*; #(
   parameter int GLYPH_CODES = 256,
   parameter int METRIC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   tlm_req_if.sink     req,
   output logic        op_valid,
   input  logic        op_ready,
   output op_item_type op_item
);

   localparam int ADDR_W = $clog2(GLYPH_CODES);
   localparam logic [8:0] CODE_LIMIT = 9'(GLYPH_CODES);

   typedef struct packed {
      logic [METRIC_BITS-2:0]        adv;
      logic signed [METRIC_BITS-1:0] bx;
      logic signed [METRIC_BITS-1:0] by;
      logic [METRIC_BITS-2:0]        sx;
      logic [METRIC_BITS-2:0]        sy;
   } glyph_entry_type;

   glyph_entry_type glyph_mem [GLYPH_CODES];
   glyph_entry_type rd_entry_ff;
   glyph_entry_type wr_entry;

   logic [GLYPH_CODES-1:0] present_ff, present_in;
   logic [ADDR_W-1:0]      addr;
   logic                   in_range;
   logic                   accept;
   logic                   write_en;

   logic stage_valid_ff, stage_valid_in;
   logic stage_end_ff, stage_newline_ff, stage_hit_ff;

   assign addr     = req.data.code[ADDR_W-1:0];
   assign in_range = ({1'b0, req.data.code} < CODE_LIMIT);
   assign req.ready = !stage_valid_ff || op_ready;
   assign accept   = req.valid && req.ready;
   assign write_en = accept && (req.data.kind == KIND_GLYPH) && in_range;

   // Trim incoming metrics to the table widths
   assign wr_entry.adv = req.data.advance_x[METRIC_BITS-2:0];
   assign wr_entry.bx  = req.data.bearing_x[METRIC_BITS-1:0];
   assign wr_entry.by  = req.data.bearing_y[METRIC_BITS-1:0];
   assign wr_entry.sx  = req.data.size_x[METRIC_BITS-2:0];
   assign wr_entry.sy  = req.data.size_y[METRIC_BITS-2:0];

   // Glyph table: write on glyph words, registered read on every accepted word
   always_ff @(posedge clock) begin
      if (write_en) begin
         glyph_mem[addr] <= wr_entry;
      end
      if (accept) begin
         rd_entry_ff <= glyph_mem[addr];
      end
   end

   // Mark entries present as they are written
   always_comb begin
      present_in = present_ff;
      if (write_en) begin
         present_in[addr] = 1'b1;
      end
   end

   // Hold a classified word until the queue takes it
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = (req.data.kind == KIND_CHAR) || (req.data.kind == KIND_END);
      end else if (op_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff     <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         present_ff     <= present_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_end_ff     <= (req.data.kind == KIND_END);
         stage_newline_ff <= (req.data.code == NEWLINE_CODE);
         stage_hit_ff     <= in_range && present_ff[addr];
      end
   end

   // Decode the operation and widen the metrics
   always_comb begin
      if (stage_end_ff) begin
         op_item.op = OP_END;
      end else if (stage_newline_ff) begin
         op_item.op = OP_NEWLINE;
      end else if (stage_hit_ff) begin
         op_item.op = OP_GLYPH;
      end else begin
         op_item.op = OP_BLANK;
      end
      op_item.adv = SIZE_W'(rd_entry_ff.adv);
      op_item.bx  = BEAR_W'(rd_entry_ff.bx);
      op_item.by  = BEAR_W'(rd_entry_ff.by);
      op_item.sx  = SIZE_W'(rd_entry_ff.sx);
      op_item.sy  = SIZE_W'(rd_entry_ff.sy);
   end

   assign op_valid = stage_valid_ff;

endmodule

FILE: rtl/core/tlm_queue.sv
// Short queue of classified operations between front and back.
module tlm_queue import tlm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  op_item_type push_item,
   output logic        pop_valid,
   input  logic        pop_ready,
   output op_item_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);

   op_item_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/core/tlm_back.sv
// Back end: accumulates line metrics and produces line and total records.
module tlm_back import tlm_pkg::*; #(
   parameter int INDEX_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  op_valid,
   output logic                  op_ready,
   input  op_item_type           op_item,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   tlm_rsp_if.source             rsp
);

   // Configuration
   logic [10:0] font_height_ff;
   logic [11:0] line_step_ff;

   // Text state
   logic [INDEX_BITS-1:0]    pos_ff, pos_in;
   logic [INDEX_BITS-1:0]    line_start_ff, line_start_in;
   logic signed [LEN_W-1:0]  acc_ff, acc_in;
   logic                     first_line_ff, first_line_in;
   logic                     line_glyph_ff, line_glyph_in;
   logic signed [SLACK_W-1:0] slack_ff, slack_in;
   logic                     last_glyph_ff, last_glyph_in;
   logic [SIZE_W-1:0]        ascent_ff, ascent_in;
   logic signed [DESC_W-1:0] descent_ff, descent_in;
   logic signed [LEN_W-1:0]  widest_ff, widest_in;
   logic [LINES_W-1:0]       extra_lines_ff, extra_lines_in;
   logic                     started_ff, started_in;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic         produce;
   logic         pop;

   // Datapath terms
   logic [INDEX_BITS-1:0]     pos_next;
   logic [INDEX_BITS+15:0]    start_ext, end_ext;
   logic signed [BEAR_W-1:0]  adv_s, sx_s, sy_s, ascent_s;
   logic signed [WIDE_W-1:0]  bx_term, glyph_sum, slack_term, closed_sum;
   logic signed [LEN_W-1:0]   closed_len, widest_upd;
   logic signed [DESC_W-1:0]  line_low;
   logic signed [SLACK_W-1:0] slack_new;
   logic [LEN_W-1:0]          line_prod;
   logic signed [WIDE_W-1:0]  fh_w, prod_w, asc_w, desc_w, height_sum;

   assign op_ready = !rsp_valid_ff || rsp.ready;
   assign pop      = op_valid && op_ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         font_height_ff <= FONT_HEIGHT_RESET;
         line_step_ff   <= LINE_STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FONT_HEIGHT: font_height_ff <= csr_wdata[10:0];
            CSR_LINE_STEP:   line_step_ff   <= csr_wdata;
            default:         line_step_ff   <= line_step_ff;
         endcase
      end
   end

   // Glyph add, line close and height terms
   always_comb begin
      pos_next   = pos_ff + 1'b1;
      start_ext  = {16'b0, line_start_ff};
      end_ext    = {16'b0, pos_ff};
      adv_s      = signed'({1'b0, op_item.adv});
      sx_s       = signed'({1'b0, op_item.sx});
      sy_s       = signed'({1'b0, op_item.sy});
      ascent_s   = signed'({1'b0, ascent_ff});
      bx_term    = line_glyph_ff ? 31'sd0 : WIDE_W'(op_item.bx);
      glyph_sum  = WIDE_W'(acc_ff) + WIDE_W'(adv_s) - bx_term;
      slack_term = last_glyph_ff ? WIDE_W'(slack_ff) : 31'sd0;
      closed_sum = WIDE_W'(acc_ff) - slack_term;
      closed_len = sat_len(closed_sum);
      widest_upd = (first_line_ff || (closed_len > widest_ff)) ? closed_len : widest_ff;
      line_low   = DESC_W'(op_item.by) - DESC_W'(sy_s);
      slack_new  = SLACK_W'(adv_s) - (SLACK_W'(op_item.bx) + SLACK_W'(sx_s));
      line_prod  = LEN_W'(extra_lines_ff) * LEN_W'(line_step_ff);
      fh_w       = signed'(WIDE_W'(font_height_ff));
      prod_w     = signed'(WIDE_W'(line_prod));
      asc_w      = signed'(WIDE_W'(ascent_ff));
      desc_w     = WIDE_W'(descent_ff);
      height_sum = fh_w + prod_w - (fh_w - asc_w) - desc_w;
   end

   // Apply one operation per popped word
   always_comb begin
      pos_in         = pos_ff;
      line_start_in  = line_start_ff;
      acc_in         = acc_ff;
      first_line_in  = first_line_ff;
      line_glyph_in  = line_glyph_ff;
      slack_in       = slack_ff;
      last_glyph_in  = last_glyph_ff;
      ascent_in      = ascent_ff;
      descent_in     = descent_ff;
      widest_in      = widest_ff;
      extra_lines_in = extra_lines_ff;
      started_in     = started_ff;
      rsp_data_in    = '0;
      produce        = 1'b0;
      if (pop) begin
         case (op_item.op)
            OP_GLYPH: begin
               started_in = 1'b1;
               if (first_line_ff && (op_item.by > ascent_s)) begin
                  ascent_in = op_item.by[SIZE_W-1:0];
               end
               acc_in = sat_len(glyph_sum);
               if (line_low < descent_ff) begin
                  descent_in = line_low;
               end
               slack_in      = slack_new;
               line_glyph_in = 1'b1;
               last_glyph_in = 1'b1;
               pos_in        = pos_next;
            end
            OP_BLANK: begin
               started_in    = 1'b1;
               last_glyph_in = 1'b0;
               pos_in        = pos_next;
            end
            OP_NEWLINE: begin
               started_in              = 1'b1;
               produce                 = 1'b1;
               widest_in               = widest_upd;
               rsp_data_in.line_valid  = 1'b1;
               rsp_data_in.line_start  = start_ext[POS_W-1:0];
               rsp_data_in.line_end    = end_ext[POS_W-1:0];
               rsp_data_in.line_length = closed_len;
               if (extra_lines_ff != '1) begin
                  extra_lines_in = extra_lines_ff + 1'b1;
               end
               first_line_in = 1'b0;
               acc_in        = '0;
               line_glyph_in = 1'b0;
               last_glyph_in = 1'b0;
               descent_in    = '0;
               line_start_in = pos_next;
               pos_in        = pos_next;
            end
            OP_END: begin
               produce              = 1'b1;
               rsp_data_in.is_final = 1'b1;
               if (started_ff) begin
                  rsp_data_in.line_valid        = 1'b1;
                  rsp_data_in.line_start        = start_ext[POS_W-1:0];
                  rsp_data_in.line_end          = end_ext[POS_W-1:0];
                  rsp_data_in.line_length       = closed_len;
                  rsp_data_in.text_width        = widest_upd;
                  rsp_data_in.text_height       = sat_len(height_sum);
                  rsp_data_in.first_line_ascent = ascent_ff;
               end
               pos_in         = '0;
               line_start_in  = '0;
               acc_in         = '0;
               first_line_in  = 1'b1;
               line_glyph_in  = 1'b0;
               slack_in       = '0;
               last_glyph_in  = 1'b0;
               ascent_in      = '0;
               descent_in     = '0;
               widest_in      = '0;
               extra_lines_in = '0;
               started_in     = 1'b0;
            end
            default: begin
               produce = 1'b0;
            end
         endcase
      end
   end

   // Drop a taken result, load a new one
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (produce) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         line_start_ff  <= '0;
         acc_ff         <= '0;
         first_line_ff  <= 1'b1;
         line_glyph_ff  <= 1'b0;
         slack_ff       <= '0;
         last_glyph_ff  <= 1'b0;
         ascent_ff      <= '0;
         descent_ff     <= '0;
         widest_ff      <= '0;
         extra_lines_ff <= '0;
         started_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         line_start_ff  <= line_start_in;
         acc_ff         <= acc_in;
         first_line_ff  <= first_line_in;
         line_glyph_ff  <= line_glyph_in;
         slack_ff       <= slack_in;
         last_glyph_ff  <= last_glyph_in;
         ascent_ff      <= ascent_in;
         descent_ff     <= descent_in;
         widest_ff      <= widest_in;
         extra_lines_ff <= extra_lines_in;
         started_ff     <= started_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

endmodule

FILE: rtl/core/text_line_metrics_unit.sv
// Top level of the text line metrics unit: front, queue and back.
//
//   channel   direction   handshake         carries
//   req       in          valid/ready       one word: glyph write, text byte or end
//   rsp       out         valid/ready       line record, or totals on end of text
//   csr       in          write enable      font_height (index 0), line_step (index 1)
//
// One word per cycle is taken in steady state while the queue has room.
// A result passes through the front stage with the glyph table's registered
// read, the queue and the result register before it is presented; a full queue
// or a held result can stall it on the way. Reset is synchronous and clears the
// glyph table's present bits in the same cycle, so no clearing pass is needed.
// Each side stalls on its own: a held result stops the back, and the front keeps
// taking words until the queue and its own stage are full.
module text_line_metrics_unit import tlm_pkg::*; #(
   parameter int GLYPH_CODES = 256,
   parameter int INDEX_BITS  = 16,
   parameter int METRIC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   tlm_req_if.sink               req,
   tlm_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic        front_valid, front_ready;
   op_item_type front_item;
   logic        back_valid, back_ready;
   op_item_type back_item;

   tlm_front #(
      .GLYPH_CODES (GLYPH_CODES),
      .METRIC_BITS (METRIC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .op_valid (front_valid),
      .op_ready (front_ready),
      .op_item  (front_item)
   );

   tlm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   tlm_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (back_valid),
      .op_ready  (back_ready),
      .op_item   (back_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp)
   );

endmodule

FILE: dv/tb_text_line_metrics_unit.sv
`timescale 1ns / 1ps
// Testbench for text_line_metrics_unit: random and directed words checked against a line predictor.
module tb_text_line_metrics_unit;
   import tlm_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [7:0] WIDE_CODE   = 8'h57;
   localparam int         STALL_LIMIT = 4000;
   localparam int         SETTLE_CYCLES = 12;
   localparam longint     LEN_TOP     = 64'sd134217727;
   localparam longint     LEN_BOTTOM  = -64'sd134217728;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic                  csr_index = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tlm_req_if req_ch ();
   tlm_rsp_if rsp_ch ();

   text_line_metrics_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Words waiting for the driver, records waiting for the block
   req_data_type words_to_send [$];
   rsp_data_type records_due [$];
   int           loaded_codes [$];

   int  words_queued   = 0;
   int  words_accepted = 0;
   int  mismatches     = 0;
   int  glyph_loads    = 0;
   int  text_bytes     = 0;
   int  line_records   = 0;
   int  totals_seen    = 0;
   int  quiet_cycles   = 0;
   int  send_gap       = 0;
   int  send_calm      = 0;
   int  take_gap       = 0;
   int  take_calm      = 0;
   bit  no_idle        = 1'b0;

   // Predictor copy of the glyph table and registers
   bit                       glyph_present [256];
   logic [SIZE_W-1:0]        glyph_adv [256];
   logic signed [BEAR_W-1:0] glyph_bx [256];
   logic signed [BEAR_W-1:0] glyph_by [256];
   logic [SIZE_W-1:0]        glyph_sx [256];
   logic [SIZE_W-1:0]        glyph_sy [256];
   logic [10:0]              font_height_q = FONT_HEIGHT_RESET;
   logic [11:0]              line_step_q   = LINE_STEP_RESET;

   // Predictor text state
   logic [POS_W-1:0]   pos_now           = '0;
   logic [POS_W-1:0]   line_first_pos    = '0;
   logic [LINES_W-1:0] lines_after_first = '0;
   longint             line_sum    = 0;
   longint             tail_slack  = 0;
   longint             top_ascent  = 0;
   longint             low_descent = 0;
   longint             widest      = 0;
   bit                 on_top_line = 1'b1;
   bit                 line_inked  = 1'b0;
   bit                 last_inked  = 1'b0;
   bit                 text_begun  = 1'b0;

   function automatic longint clamp_len(input longint v);
      if (v > LEN_TOP) return LEN_TOP;
      if (v < LEN_BOTTOM) return LEN_BOTTOM;
      return v;
   endfunction

   task automatic clear_text();
      pos_now           = '0;
      line_first_pos    = '0;
      lines_after_first = '0;
      line_sum          = 0;
      tail_slack        = 0;
      top_ascent        = 0;
      low_descent       = 0;
      widest            = 0;
      on_top_line       = 1'b1;
      line_inked        = 1'b0;
      last_inked        = 1'b0;
      text_begun        = 1'b0;
   endtask

   // Trim the last glyph's right slack and track the widest line
   function automatic longint close_line();
      longint len;
      len = line_sum;
      if (last_inked) len = clamp_len(len - tail_slack);
      if (on_top_line || len > widest) widest = len;
      return len;
   endfunction

   // Advance the predictor by one accepted word and queue any record it yields
   task automatic measure_word(input req_data_type w);
      rsp_data_type rec;
      longint       adv, bx, by, sx, sy, low, len, tall;
      rec = '0;
      case (w.kind)
         KIND_GLYPH: begin
            glyph_present[w.code] = 1'b1;
            glyph_adv[w.code]     = w.advance_x;
            glyph_bx[w.code]      = w.bearing_x;
            glyph_by[w.code]      = w.bearing_y;
            glyph_sx[w.code]      = w.size_x;
            glyph_sy[w.code]      = w.size_y;
            glyph_loads++;
         end
         KIND_CHAR: begin
            text_bytes++;
            text_begun = 1'b1;
            if (w.code == NEWLINE_CODE) begin
               len = close_line();
               rec.line_valid  = 1'b1;
               rec.line_start  = line_first_pos;
               rec.line_end    = pos_now;
               rec.line_length = len[LEN_W-1:0];
               records_due = {records_due, rec};
               if (lines_after_first != '1) lines_after_first++;
               on_top_line    = 1'b0;
               line_sum       = 0;
               line_inked     = 1'b0;
               last_inked     = 1'b0;
               low_descent    = 0;
               pos_now        = pos_now + 1'b1;
               line_first_pos = pos_now;
            end else begin
               if (glyph_present[w.code]) begin
                  adv = glyph_adv[w.code];
                  bx  = glyph_bx[w.code];
                  by  = glyph_by[w.code];
                  sx  = glyph_sx[w.code];
                  sy  = glyph_sy[w.code];
                  low = by - sy;
                  if (on_top_line && by > top_ascent) top_ascent = by;
                  if (line_inked) line_sum = clamp_len(line_sum + adv);
                  else line_sum = clamp_len(line_sum + adv - bx);
                  if (low < low_descent) low_descent = low;
                  tail_slack = adv - (bx + sx);
                  line_inked = 1'b1;
                  last_inked = 1'b1;
               end else begin
                  last_inked = 1'b0;
               end
               pos_now = pos_now + 1'b1;
            end
         end
         KIND_END: begin
            rec.is_final = 1'b1;
            if (text_begun) begin
               len  = close_line();
               tall = longint'(font_height_q)
                      + longint'(lines_after_first) * longint'(line_step_q)
                      - (longint'(font_height_q) - top_ascent) - low_descent;
               tall = clamp_len(tall);
               rec.line_valid        = 1'b1;
               rec.line_start        = line_first_pos;
               rec.line_end          = pos_now;
               rec.line_length       = len[LEN_W-1:0];
               rec.text_width        = widest[LEN_W-1:0];
               rec.text_height       = tall[LEN_W-1:0];
               rec.first_line_ascent = top_ascent[SIZE_W-1:0];
            end
            records_due = {records_due, rec};
            clear_text();
         end
         default: ;
      endcase
   endtask

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Compare one result word with the oldest pending record
   task automatic check_result(input rsp_data_type got);
      rsp_data_type want;
      if (records_due.size() == 0) begin
         flag_mismatch("result with nothing pending, line_end", got.line_end, 0);
      end else begin
         want = records_due.pop_front();
         if (got.line_valid !== want.line_valid)
            flag_mismatch("line_valid", got.line_valid, want.line_valid);
         if (got.line_start !== want.line_start)
            flag_mismatch("line_start", got.line_start, want.line_start);
         if (got.line_end !== want.line_end)
            flag_mismatch("line_end", got.line_end, want.line_end);
         if (got.line_length !== want.line_length)
            flag_mismatch("line_length", got.line_length, want.line_length);
         if (got.is_final !== want.is_final)
            flag_mismatch("is_final", got.is_final, want.is_final);
         if (got.text_width !== want.text_width)
            flag_mismatch("text_width", got.text_width, want.text_width);
         if (got.text_height !== want.text_height)
            flag_mismatch("text_height", got.text_height, want.text_height);
         if (got.first_line_ascent !== want.first_line_ascent)
            flag_mismatch("first_line_ascent", got.first_line_ascent, want.first_line_ascent);
         if (want.is_final) totals_seen++;
         else line_records++;
      end
   endtask

   // Mostly back-to-back, some short gaps, a few long ones, now and then a calm stretch
   function automatic int pick_gap(inout int calm_left);
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if (roll < 3) begin
         calm_left = $urandom_range(40, 150);
         return 0;
      end
      if (roll < 62) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Drive request words from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            measure_word(req_ch.data);
            words_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (words_to_send.size() > 0) begin
               req_ch.data  <= words_to_send.pop_front();
               req_ch.valid <= 1'b1;
               send_gap = pick_gap(send_calm);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Take result words with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_result(rsp_ch.data);
         if (take_gap > 0) begin
            take_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            take_gap = pick_gap(take_calm);
         end
      end
   end

   // Drop the run when neither side moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL text_line_metrics_unit");
         $finish;
      end
   end

   task automatic send(input req_data_type w);
      words_to_send = {words_to_send, w};
      words_queued++;
   endtask

   function automatic req_data_type glyph_word(input logic [7:0] code, input int adv,
                                               input int bx, input int by,
                                               input int sx, input int sy);
      req_data_type w;
      w = '0;
      w.kind      = KIND_GLYPH;
      w.code      = code;
      w.advance_x = SIZE_W'(adv);
      w.bearing_x = BEAR_W'(bx);
      w.bearing_y = BEAR_W'(by);
      w.size_x    = SIZE_W'(sx);
      w.size_y    = SIZE_W'(sy);
      return w;
   endfunction

   // Fill every field with random bits
   function automatic req_data_type noise_word();
      logic [95:0] raw;
      raw = {$urandom(), $urandom(), $urandom()};
      return raw[$bits(req_data_type)-1:0];
   endfunction

   // Metric fields of text and end words carry noise the block must ignore
   function automatic req_data_type char_word(input logic [7:0] code);
      req_data_type w;
      w      = noise_word();
      w.kind = KIND_CHAR;
      w.code = code;
      return w;
   endfunction

   function automatic req_data_type end_word();
      req_data_type w;
      w      = noise_word();
      w.kind = KIND_END;
      return w;
   endfunction

   function automatic req_data_type odd_word();
      req_data_type w;
      w      = noise_word();
      w.kind = KIND_UNUSED;
      return w;
   endfunction

   task automatic queue_random_glyph();
      int code;
      code = $urandom_range(0, 255);
      loaded_codes = {loaded_codes, code};
      send(glyph_word(8'(code), $urandom_range(0, 2047), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 2047),
                      $urandom_range(0, 2047)));
   endtask

   // Mostly text from loaded codes, with newlines, ends, reloads and noise
   task automatic queue_text_mix(input int count);
      int made;
      int roll;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            queue_random_glyph();
            made++;
         end else if (roll < 5) begin
            send(odd_word());
         end else if (roll < 9) begin
            send(end_word());
            made++;
         end else if (roll < 22) begin
            send(char_word(NEWLINE_CODE));
            made++;
         end else if (roll < 72 && loaded_codes.size() > 0) begin
            send(char_word(8'(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)])));
            made++;
         end else begin
            send(char_word(8'($urandom_range(0, 255))));
            made++;
         end
      end
      send(end_word());
   endtask

   // Hold until every word is taken and every record has come, then let the pipe drain
   task automatic settle();
      while (!(words_accepted == words_queued && records_due.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FONT_HEIGHT) font_height_q = value[10:0];
      else line_step_q = value[11:0];
   endtask

   task automatic random_phase(input int height, input int step, input int count);
      settle();
      write_csr(CSR_FONT_HEIGHT, CSR_DATA_W'(height));
      write_csr(CSR_LINE_STEP, CSR_DATA_W'(step));
      repeat (12) queue_random_glyph();
      queue_text_mix(count);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty text, extreme metrics, blank lines, missing glyphs
      send(end_word());
      send(glyph_word(8'h41, 2047, -2048, 2047, 2047, 2047));
      send(glyph_word(8'h42, 0, 2047, -2048, 0, 0));
      send(glyph_word(8'hFF, 1234, 5, 10, 3, 20));
      send(glyph_word(8'h00, 7, 0, 0, 0, 0));
      send(glyph_word(NEWLINE_CODE, 100, -3, 50, 9, 9));
      send(char_word(8'h42));
      send(char_word(8'h41));
      send(char_word(8'h5A));
      send(char_word(8'h41));
      send(char_word(NEWLINE_CODE));
      send(char_word(NEWLINE_CODE));
      send(char_word(8'hFF));
      send(char_word(8'h00));
      send(char_word(8'h41));
      send(char_word(8'h5A));
      send(end_word());
      send(odd_word());
      send(char_word(NEWLINE_CODE));
      send(end_word());
      send(char_word(8'h5A));
      send(end_word());
      repeat (20) queue_random_glyph();
      queue_text_mix(280);

      random_phase(2047, 4095, 280);
      random_phase(1, 0, 280);
      random_phase($urandom_range(1, 2047), $urandom_range(0, 4095), 280);

      // One burst with no idling: wide glyphs, then a run of blank lines
      settle();
      write_csr(CSR_LINE_STEP, CSR_DATA_W'(4095));
      no_idle = 1'b1;
      send(glyph_word(WIDE_CODE, 2047, 0, 2047, 0, 0));
      repeat (60) send(char_word(WIDE_CODE));
      repeat (40) send(char_word(NEWLINE_CODE));
      send(end_word());
      settle();
      no_idle = 1'b0;

      random_phase($urandom_range(1, 2047), $urandom_range(0, 4095), 280);
      settle();

      if (records_due.size() != 0)
         flag_mismatch("records never returned", records_due.size(), 0);
      $display("covered %0d words: %0d glyph loads, %0d text bytes; %0d lines, %0d totals",
               words_accepted, glyph_loads, text_bytes, line_records, totals_seen);
      $display("register settings: reset, maxima, minima, random; one gapless burst");
      if (mismatches == 0) begin
         $display("PASS text_line_metrics_unit");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL text_line_metrics_unit");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/tlm_pkg.sv
rtl/core/tlm_channels.sv
rtl/core/tlm_front.sv
rtl/core/tlm_queue.sv
rtl/core/tlm_back.sv
rtl/core/text_line_metrics_unit.sv
dv/tb_text_line_metrics_unit.sv
